@@ rtl/core/tss_pkg.sv @@
// shared constants, command codes and types of the touch slider scanner
package tss_pkg;

  localparam int MAX_ELEC_DEF = 16;
  localparam int CNT_W        = 16;
  localparam int CH_W         = 4;
  localparam int MAP_W        = 64;
  localparam int EC_W         = 5;
  localparam int LEN_W        = 8;
  localparam int PCT_W        = 7;
  localparam int NUM_W        = CNT_W + PCT_W;
  localparam int DEN_W        = CNT_W + 1;
  localparam int CFG_IDX_W    = 3;
  localparam int SCALE_W      = PCT_W + LEN_W;
  localparam int RECIP_W      = 15;
  localparam int RECIP_S      = 21;
  localparam int RC_W         = SCALE_W + RECIP_W;

  localparam logic [EC_W-1:0]    EC_RESET   = 5'd2;
  localparam logic [MAP_W-1:0]   MAP_RESET  = 64'd169;
  localparam logic [LEN_W-1:0]   LEN_RESET  = 8'd40;
  localparam logic [CNT_W-1:0]   THR_RESET  = 16'd100;
  localparam logic [PCT_W-1:0]   PCT_FULL   = 7'd100;
  // ceil(2^21 / 100): exact division by 100 for products below 43690
  localparam logic [RECIP_W-1:0] RECIP_K    = 15'd20972;

  typedef enum logic [1:0] {
    CMD_CALIB = 2'd0,
    CMD_SCAN  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ELEC_COUNT = 3'd0,
    CFG_CHAN_MAP   = 3'd1,
    CFG_SLIDER_LEN = 3'd2,
    CFG_THRESHOLD  = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [PCT_W-1:0] pct_left;
    logic [PCT_W-1:0] pct_right;
    logic [LEN_W-1:0] dist_left;
    logic [LEN_W-1:0] dist_right;
    logic [PCT_W-1:0] abs_pct;
    logic [LEN_W-1:0] abs_dist;
  } held_t;

  typedef struct packed {
    logic busy;
    logic done;
  } pos_stat_t;

endpackage

@@ rtl/core/tss_table.sv @@
// per-electrode count table: synchronous memory, registered read, valid bits for zero reset
module tss_table import tss_pkg::*; #(
  parameter int DEPTH = MAX_ELEC_DEF,
  parameter int IDX_W = $clog2(MAX_ELEC_DEF)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [CNT_W-1:0] wr_data,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [CNT_W-1:0] rd_data
);

  logic [CNT_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [CNT_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    // entries never written read as zero
    rd_data_r <= vld_r[rd_idx] ? mem[rd_idx] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_idx] <= 1'b1;
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/tss_divider.sv @@
// restoring divider, one quotient bit per cycle, quotient known to fit in PCT_W bits
module tss_divider import tss_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [PCT_W-1:0] quotient
);

  localparam int STEP_W = $clog2(PCT_W);

  logic [NUM_W-1:0]  rem_r;
  logic [NUM_W-1:0]  dvs_r;
  logic [PCT_W-1:0]  quo_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic              ge;

  assign ge = (rem_r >= dvs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(PCT_W - 1);
      end else if (busy_r) begin
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dvs_r <= NUM_W'(divisor) << (PCT_W - 1);
      quo_r <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dvs_r;
      end
      quo_r <= {quo_r[PCT_W-2:0], ge};
      dvs_r <= dvs_r >> 1;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ rtl/core/tss_position.sv @@
// slider position sequencer: percent shares, distances and absolute position, held values
module tss_position import tss_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CNT_W-1:0] d0,
  input  logic [CNT_W-1:0] d1,
  input  logic [CNT_W-1:0] thresh,
  input  logic [LEN_W-1:0] slider_len,
  output pos_stat_t        stat,
  output held_t            held
);

  typedef enum logic [2:0] {
    P_IDLE, P_DIV0, P_DIV1, P_SCALE, P_RC0, P_RC1, P_FIN
  } pstate_t;

  pstate_t            pstate_r;
  held_t              held_r;
  logic               done_r;
  logic [CNT_W-1:0]   d1_r;
  logic [DEN_W-1:0]   sum_r;
  logic [PCT_W-1:0]   p0_r;
  logic [PCT_W-1:0]   p1_r;
  logic [SCALE_W-1:0] prod0_r;
  logic [SCALE_W-1:0] prod1_r;
  logic [LEN_W-1:0]   s0_r;
  logic [LEN_W-1:0]   s1_r;

  logic               touched;
  logic               div_start;
  logic               div_done;
  logic [PCT_W-1:0]   div_q;
  logic [CNT_W-1:0]   mult_a;
  logic [NUM_W-1:0]   dividend;
  logic [DEN_W-1:0]   divisor;
  logic [SCALE_W-1:0] rc_in;
  logic [RC_W-1:0]    rc_prod;
  logic [PCT_W:0]     abs_pct_sum;
  logic [LEN_W:0]     abs_dist_sum;

  assign touched   = (d0 > thresh) || (d1 > thresh);
  assign div_start = ((pstate_r == P_IDLE) && start && touched) ||
                     ((pstate_r == P_DIV0) && div_done);
  assign mult_a    = (pstate_r == P_IDLE) ? d0 : d1_r;
  assign dividend  = NUM_W'(mult_a) * NUM_W'(PCT_FULL);
  assign divisor   = (pstate_r == P_IDLE) ? (DEN_W'(d0) + DEN_W'(d1)) : sum_r;

  // division by 100 through the reciprocal, shared by both distances
  assign rc_in   = (pstate_r == P_RC0) ? prod0_r : prod1_r;
  assign rc_prod = RC_W'(rc_in) * RC_W'(RECIP_K);

  assign abs_pct_sum  = ((PCT_W+1)'(PCT_FULL) - (PCT_W+1)'(p0_r)) + (PCT_W+1)'(p1_r);
  assign abs_dist_sum = ((LEN_W+1)'(slider_len) - (LEN_W+1)'(s0_r)) + (LEN_W+1)'(s1_r);

  tss_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pstate_r <= P_IDLE;
      held_r   <= '0;
      done_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (pstate_r)
        P_IDLE: begin
          if (start) begin
            if (touched) begin
              sum_r    <= DEN_W'(d0) + DEN_W'(d1);
              d1_r     <= d1;
              pstate_r <= P_DIV0;
            end else begin
              held_r <= '0;
              done_r <= 1'b1;
            end
          end
        end
        P_DIV0: begin
          if (div_done) begin
            p0_r     <= div_q;
            pstate_r <= P_DIV1;
          end
        end
        P_DIV1: begin
          if (div_done) begin
            p1_r     <= div_q;
            pstate_r <= P_SCALE;
          end
        end
        P_SCALE: begin
          prod0_r  <= SCALE_W'(p0_r) * SCALE_W'(slider_len);
          prod1_r  <= SCALE_W'(p1_r) * SCALE_W'(slider_len);
          pstate_r <= P_RC0;
        end
        P_RC0: begin
          s0_r     <= rc_prod[RECIP_S +: LEN_W];
          pstate_r <= P_RC1;
        end
        P_RC1: begin
          s1_r     <= rc_prod[RECIP_S +: LEN_W];
          pstate_r <= P_FIN;
        end
        P_FIN: begin
          held_r.pct_left   <= p0_r;
          held_r.pct_right  <= p1_r;
          held_r.dist_left  <= s0_r;
          held_r.dist_right <= s1_r;
          held_r.abs_pct    <= abs_pct_sum[PCT_W:1];
          held_r.abs_dist   <= abs_dist_sum[LEN_W:1];
          done_r            <= 1'b1;
          pstate_r          <= P_IDLE;
        end
        default: begin
          pstate_r <= P_IDLE;
        end
      endcase
    end
  end

  assign stat.busy = (pstate_r != P_IDLE);
  assign stat.done = done_r;
  assign held      = held_r;

endmodule

@@ rtl/core/touch_slider_scanner_core.sv @@
// top level of the touch slider scanner: control, configuration, tables and result register
//
//  channel | direction | ports
//  --------+-----------+----------------------------------------------------------------
//  in      | request   | in_valid, in_ready, in_command, in_scan_count
//  out     | result    | out_valid, out_ready, out_next_channel, out_start_scan, position
//  cfg     | write     | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// one request at a time: calibration and no-op/held reads go straight to the result
// stage, a scan first waits on the baseline memory read, and a read after a scan
// waits on the two seven-step serial divisions. reset leaves both tables reading zero
// through per-entry valid bits, so no clearing pass is needed. a finished result waits
// in the output register while the next request is taken and worked on.
module touch_slider_scanner_core import tss_pkg::*; #(
  parameter int MAX_ELECTRODES = MAX_ELEC_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_command,
  input  logic [CNT_W-1:0]     in_scan_count,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CH_W-1:0]      out_next_channel,
  output logic                 out_start_scan,
  output logic [PCT_W-1:0]     out_pct_left,
  output logic [PCT_W-1:0]     out_pct_right,
  output logic [LEN_W-1:0]     out_dist_left,
  output logic [LEN_W-1:0]     out_dist_right,
  output logic [PCT_W-1:0]     out_abs_pct,
  output logic [LEN_W-1:0]     out_abs_dist,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MAP_W-1:0]     cfg_data
);

  localparam int IDX_W = $clog2(MAX_ELECTRODES);
  localparam logic [EC_W-1:0] MAX_N = EC_W'(MAX_ELECTRODES);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_RD0, S_RD1, S_CALC, S_DONE
  } state_t;

  state_t           state_r;
  logic [EC_W-1:0]  elec_cnt_r;
  logic [MAP_W-1:0] chan_map_r;
  logic [LEN_W-1:0] slider_len_r;
  logic [CNT_W-1:0] thresh_r;
  logic [IDX_W-1:0] scan_idx_r;
  logic [IDX_W-1:0] calib_idx_r;
  logic             pending_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] d0_r;
  logic [CH_W-1:0]  chan_r;
  logic             start_r;
  logic             out_valid_r;
  logic [CH_W-1:0]  out_chan_r;
  logic             out_start_r;
  held_t            out_held_r;

  logic             in_fire;
  logic             out_load;
  logic [EC_W-1:0]  eff_n;
  logic [EC_W-1:0]  n_m1;
  logic [IDX_W-1:0] calib_idx_nxt;
  logic [IDX_W-1:0] scan_idx_nxt;
  logic             bl_wr_en;
  logic [CNT_W-1:0] bl_rd_data;
  logic             dl_wr_en;
  logic [IDX_W-1:0] dl_rd_idx;
  logic [CNT_W-1:0] dl_rd_data;
  logic [CNT_W-1:0] delta;
  logic             pos_start;
  pos_stat_t        pos_st;
  held_t            pos_held;

  function automatic logic [CH_W-1:0] chan_of(input logic [MAP_W-1:0] map,
                                              input logic [IDX_W-1:0] e);
    logic [5:0] base;
    base = 6'(e) << 2;
    return map[base +: CH_W];
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // electrode count clamped to 1..MAX_ELECTRODES
  assign eff_n = (elec_cnt_r == '0)  ? EC_W'(1) :
                 (elec_cnt_r > MAX_N) ? MAX_N : elec_cnt_r;
  assign n_m1  = eff_n - 1'b1;

  assign calib_idx_nxt = (EC_W'(calib_idx_r) < n_m1) ? calib_idx_r + 1'b1 : '0;
  assign scan_idx_nxt  = (EC_W'(scan_idx_r) < n_m1) ? scan_idx_r + 1'b1 : '0;

  assign bl_wr_en  = in_fire && (in_command == CMD_CALIB);
  assign dl_wr_en  = (state_r == S_SCAN);
  assign delta     = (cnt_r > bl_rd_data) ? cnt_r - bl_rd_data : '0;
  // electrode 0 is read on acceptance, electrode 1 the cycle after
  assign dl_rd_idx = (state_r == S_RD0) ? IDX_W'(1) : '0;
  assign pos_start = (state_r == S_RD1);

  tss_table #(.DEPTH(MAX_ELECTRODES), .IDX_W(IDX_W)) u_baseline (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (bl_wr_en),
    .wr_idx  (calib_idx_r),
    .wr_data (in_scan_count),
    .rd_idx  (scan_idx_r),
    .rd_data (bl_rd_data)
  );

  tss_table #(.DEPTH(MAX_ELECTRODES), .IDX_W(IDX_W)) u_delta (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (dl_wr_en),
    .wr_idx  (scan_idx_r),
    .wr_data (delta),
    .rd_idx  (dl_rd_idx),
    .rd_data (dl_rd_data)
  );

  tss_position u_pos (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (pos_start),
    .d0         (d0_r),
    .d1         (dl_rd_data),
    .thresh     (thresh_r),
    .slider_len (slider_len_r),
    .stat       (pos_st),
    .held       (pos_held)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elec_cnt_r   <= EC_RESET;
      chan_map_r   <= MAP_RESET;
      slider_len_r <= LEN_RESET;
      thresh_r     <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ELEC_COUNT: elec_cnt_r   <= cfg_data[EC_W-1:0];
        CFG_CHAN_MAP:   chan_map_r   <= cfg_data;
        CFG_SLIDER_LEN: slider_len_r <= cfg_data[LEN_W-1:0];
        CFG_THRESHOLD:  thresh_r     <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_idx_r  <= '0;
      calib_idx_r <= '0;
      pending_r   <= 1'b1;
      out_valid_r <= 1'b0;
      chan_r      <= '0;
      start_r     <= 1'b0;
      out_chan_r  <= '0;
      out_start_r <= 1'b0;
      out_held_r  <= '0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            cnt_r   <= in_scan_count;
            chan_r  <= chan_of(chan_map_r, scan_idx_r);
            start_r <= 1'b0;
            state_r <= S_DONE;
            case (in_command)
              CMD_CALIB: begin
                calib_idx_r <= calib_idx_nxt;
                if (calib_idx_nxt == '0) begin
                  scan_idx_r <= '0;
                end
                chan_r  <= chan_of(chan_map_r, calib_idx_nxt);
                start_r <= 1'b1;
              end
              CMD_SCAN: begin
                state_r <= S_SCAN;
              end
              CMD_READ: begin
                if (pending_r) begin
                  pending_r <= 1'b0;
                  state_r   <= S_RD0;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          pending_r <= 1'b1;
          if (eff_n > EC_W'(1)) begin
            scan_idx_r <= scan_idx_nxt;
            chan_r     <= chan_of(chan_map_r, scan_idx_nxt);
            start_r    <= 1'b1;
          end
          state_r <= S_DONE;
        end
        S_RD0: begin
          d0_r    <= dl_rd_data;
          state_r <= S_RD1;
        end
        S_RD1: begin
          state_r <= S_CALC;
        end
        S_CALC: begin
          if (pos_st.done) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            out_chan_r  <= chan_r;
            out_start_r <= start_r;
            out_held_r  <= pos_held;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_next_channel = out_chan_r;
  assign out_start_scan   = out_start_r;
  assign out_pct_left     = out_held_r.pct_left;
  assign out_pct_right    = out_held_r.pct_right;
  assign out_dist_left    = out_held_r.dist_left;
  assign out_dist_right   = out_held_r.dist_right;
  assign out_abs_pct      = out_held_r.abs_pct;
  assign out_abs_dist     = out_held_r.abs_dist;

  // position unit only runs while the controller waits for it
  a_pos_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    pos_st.busy |-> state_r == S_CALC)
    else $error("position unit busy outside calculation state");

  a_read_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_command == CMD_READ) |=> !pending_r)
    else $error("read request left scan pending set");

  a_scan_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |=> pending_r)
    else $error("scan end did not mark a pending scan");

  a_shares_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (8'(out_pct_left) + 8'(out_pct_right)) <= 8'd100)
    else $error("electrode shares exceed one hundred percent");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (EC_W'(scan_idx_r) < MAX_N) && (EC_W'(calib_idx_r) < MAX_N))
    else $error("electrode index beyond table depth");

endmodule

@@ verif/tb_touch_slider_scanner_core.sv @@
// self-checking testbench of the touch slider scanner core with its own slider position predictor
module tb_touch_slider_scanner_core;
  import tss_pkg::*;

  localparam int ELECTRODES     = MAX_ELEC_DEF;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 85;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES    = 60;
  localparam int CYCLE_LIMIT    = 400000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd5;

  typedef enum logic [1:0] {ACT_REQ, ACT_WRITE, ACT_DRAIN, ACT_HOLD} act_t;

  typedef struct {
    act_t                 act;
    cmd_t                 cmd;
    logic [CNT_W-1:0]     cnt;
    logic [CFG_IDX_W-1:0] idx;
    logic [MAP_W-1:0]     data;
    int                   gap;
  } plan_t;

  typedef struct packed {
    logic [CH_W-1:0] chan;
    logic            start;
    held_t           pos;
  } readout_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_command = CMD_NOP;
  logic [CNT_W-1:0]     in_scan_count = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CH_W-1:0]      out_next_channel;
  logic                 out_start_scan;
  logic [PCT_W-1:0]     out_pct_left;
  logic [PCT_W-1:0]     out_pct_right;
  logic [LEN_W-1:0]     out_dist_left;
  logic [LEN_W-1:0]     out_dist_right;
  logic [PCT_W-1:0]     out_abs_pct;
  logic [LEN_W-1:0]     out_abs_dist;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MAP_W-1:0]     cfg_data = '0;
  logic                 rx_hold_go = 1'b0;

  // predictor state and register copies
  logic [CNT_W-1:0] base_mem [16];
  logic [CNT_W-1:0] delta_mem [16];
  logic [3:0]       scan_ix;
  logic [3:0]       cal_ix;
  logic             scan_fresh;
  held_t            held;
  logic [EC_W-1:0]  m_ecount;
  logic [MAP_W-1:0] m_map;
  logic [LEN_W-1:0] m_len;
  logic [CNT_W-1:0] m_thr;

  plan_t    plan_q[$];
  readout_t slider_readouts_q[$];

  int n_planned, n_req, n_res, n_cfg, n_touch, mismatches, cycles;
  int burst_left, tx_idle, rx_wait;
  bit tx_quiet, rx_busy;
  int rx_hold_once = 0;
  int drain_once = 0;

  touch_slider_scanner_core #(.MAX_ELECTRODES(ELECTRODES)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_scan_count(in_scan_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_next_channel(out_next_channel), .out_start_scan(out_start_scan),
    .out_pct_left(out_pct_left), .out_pct_right(out_pct_right),
    .out_dist_left(out_dist_left), .out_dist_right(out_dist_right),
    .out_abs_pct(out_abs_pct), .out_abs_dist(out_abs_dist),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned rotation_len(logic [EC_W-1:0] ec);
    int unsigned n;
    n = ec;
    if (n < 1) n = 1;
    if (n > ELECTRODES) n = ELECTRODES;
    return n;
  endfunction

  function automatic logic [CH_W-1:0] map_channel(logic [3:0] e);
    return CH_W'(m_map >> (e * 4));
  endfunction

  // one request through the slider: updates the tables and returns the readout it causes
  function automatic readout_t advance_slider(cmd_t cmd, logic [CNT_W-1:0] cnt);
    readout_t    r;
    int unsigned n, d0, d1, sum, p0, p1, s0, s1, ln, full;
    n = rotation_len(m_ecount);
    r.chan = map_channel(scan_ix);
    r.start = 1'b0;
    case (cmd)
      CMD_CALIB: begin
        base_mem[cal_ix] = cnt;
        if (cal_ix < n - 1) begin
          cal_ix = cal_ix + 4'd1;
          r.chan = map_channel(cal_ix);
        end else begin
          cal_ix = '0;
          scan_ix = '0;
          r.chan = map_channel(4'd0);
        end
        r.start = 1'b1;
      end
      CMD_SCAN: begin
        delta_mem[scan_ix] = (cnt > base_mem[scan_ix]) ? cnt - base_mem[scan_ix] : '0;
        scan_fresh = 1'b1;
        if (n > 1) begin
          if (scan_ix < n - 1) scan_ix = scan_ix + 4'd1;
          else scan_ix = '0;
          r.chan = map_channel(scan_ix);
          r.start = 1'b1;
        end
      end
      CMD_READ: begin
        if (scan_fresh) begin
          scan_fresh = 1'b0;
          d0 = delta_mem[0];
          d1 = delta_mem[1];
          ln = m_len;
          full = PCT_FULL;
          if (d0 > m_thr || d1 > m_thr) begin
            sum = d0 + d1;
            p0 = d0 * full / sum;
            p1 = d1 * full / sum;
            s0 = p0 * ln / full;
            s1 = p1 * ln / full;
            held.pct_left   = PCT_W'(p0);
            held.pct_right  = PCT_W'(p1);
            held.dist_left  = LEN_W'(s0);
            held.dist_right = LEN_W'(s1);
            held.abs_pct    = PCT_W'(((full - p0) + p1) / 2);
            held.abs_dist   = LEN_W'(((ln - s0) + s1) / 2);
            n_touch++;
          end else begin
            held = '0;
          end
        end
      end
      default: ;
    endcase
    r.pos = held;
    return r;
  endfunction

  task automatic plan_req(input cmd_t c, input int unsigned v);
    plan_t e;
    e.act = ACT_REQ;
    e.cmd = c;
    e.cnt = v[CNT_W-1:0];
    e.idx = '0;
    e.data = '0;
    if (burst_left > 0) begin
      e.gap = 0;
      burst_left--;
    end else begin
      e.gap = tx_quiet ? 0 : $urandom_range(0, 17);
    end
    plan_q.push_back(e);
    n_planned++;
  endtask

  task automatic plan_write(input logic [CFG_IDX_W-1:0] idx, input logic [MAP_W-1:0] value);
    plan_t e;
    e.act = ACT_WRITE;
    e.cmd = CMD_NOP;
    e.cnt = '0;
    e.idx = idx;
    e.data = value;
    e.gap = 0;
    plan_q.push_back(e);
  endtask

  task automatic plan_marker(input act_t a);
    plan_t e;
    e.act = a;
    e.cmd = CMD_NOP;
    e.cnt = '0;
    e.idx = '0;
    e.data = '0;
    e.gap = 0;
    plan_q.push_back(e);
  endtask

  function automatic int unsigned clamp16(int x);
    if (x < 0) return 0;
    if (x > 65535) return 65535;
    return x;
  endfunction

  task automatic check_field(input string what, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
      mismatches++;
    end
  endtask

  // request and register write driver, predictor updated on every accepted request
  always @(posedge clk) begin
    plan_t head;
    logic  v_in, v_cfg, v_hold;
    if (!rst_n) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
      rx_hold_go <= 1'b0;
      tx_idle = 0;
      for (int i = 0; i < 16; i++) begin
        base_mem[i] = '0;
        delta_mem[i] = '0;
      end
      scan_ix = '0;
      cal_ix = '0;
      scan_fresh = 1'b1;
      held = '0;
      m_ecount = EC_RESET;
      m_map = MAP_RESET;
      m_len = LEN_RESET;
      m_thr = THR_RESET;
    end else begin
      v_in = in_valid;
      v_cfg = cfg_valid;
      v_hold = 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ELEC_COUNT: m_ecount = cfg_data[EC_W-1:0];
          CFG_CHAN_MAP:   m_map = cfg_data;
          CFG_SLIDER_LEN: m_len = cfg_data[LEN_W-1:0];
          CFG_THRESHOLD:  m_thr = cfg_data[CNT_W-1:0];
          default: ;
        endcase
        n_cfg++;
        v_cfg = 1'b0;
      end
      if (in_valid && in_ready) begin
        slider_readouts_q.push_back(advance_slider(cmd_t'(in_command), in_scan_count));
        n_req++;
        v_in = 1'b0;
      end
      if (!v_in && !v_cfg && plan_q.size() != 0) begin
        head = plan_q[0];
        case (head.act)
          ACT_REQ: begin
            if (tx_idle >= head.gap) begin
              v_in = 1'b1;
              in_command <= head.cmd;
              in_scan_count <= head.cnt;
              void'(plan_q.pop_front());
              tx_idle = 0;
            end else begin
              tx_idle++;
            end
          end
          ACT_WRITE: begin
            // registers only change with the block idle
            if (slider_readouts_q.size() == 0) begin
              v_cfg = 1'b1;
              cfg_index <= head.idx;
              cfg_data <= head.data;
              void'(plan_q.pop_front());
            end
          end
          ACT_DRAIN: begin
            if (slider_readouts_q.size() == 0) void'(plan_q.pop_front());
          end
          default: begin
            v_hold = 1'b1;
            void'(plan_q.pop_front());
          end
        endcase
      end
      in_valid <= v_in;
      cfg_valid <= v_cfg;
      rx_hold_go <= v_hold;
    end
  end

  // readout monitor and receiver back-pressure
  always @(posedge clk) begin
    readout_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait = 0;
      rx_busy = 1'b1;
    end else begin
      if (out_valid && out_ready) begin
        if (slider_readouts_q.size() == 0) begin
          $display("%0t: readout with no request outstanding, channel %0d", $time,
                   out_next_channel);
          mismatches++;
        end else begin
          want = slider_readouts_q.pop_front();
          check_field("next_channel", want.chan, out_next_channel);
          check_field("start_scan", want.start, out_start_scan);
          check_field("pct_left", want.pos.pct_left, out_pct_left);
          check_field("pct_right", want.pos.pct_right, out_pct_right);
          check_field("dist_left", want.pos.dist_left, out_dist_left);
          check_field("dist_right", want.pos.dist_right, out_dist_right);
          check_field("abs_pct", want.pos.abs_pct, out_abs_pct);
          check_field("abs_dist", want.pos.abs_dist, out_abs_dist);
        end
        n_res++;
        if (n_res % 48 == 0) rx_busy = ($urandom_range(0, 2) != 0);
        rx_wait = rx_busy ? $urandom_range(0, 17) : 0;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      if (rx_hold_go) rx_wait = RX_HOLD_CYCLES;
      out_ready <= (rx_wait == 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d readouts outstanding", cycles,
               slider_readouts_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    logic [EC_W-1:0]  ec;
    logic [MAP_W-1:0] map;
    logic [LEN_W-1:0] ln;
    logic [CNT_W-1:0] thr;
    logic [MAP_W-1:0] word;
    int unsigned      rot, lvl, start_n;
    int               offs;

    tx_quiet = 1'b0;
    // reset settings: two electrodes on channels 9 and 10, threshold 100
    plan_req(CMD_READ, 0);
    plan_req(CMD_NOP, 16'hFFFF);
    plan_req(CMD_CALIB, 0);
    plan_req(CMD_CALIB, 16'hFFFF);
    plan_req(CMD_SCAN, 16'hFFFF);
    plan_req(CMD_SCAN, 0);          // count below baseline
    plan_req(CMD_READ, 0);
    plan_req(CMD_READ, 0);          // nothing new, held values
    plan_req(CMD_CALIB, 1000);
    plan_req(CMD_CALIB, 1000);
    plan_req(CMD_SCAN, 1000);
    plan_req(CMD_SCAN, 999);
    plan_req(CMD_READ, 0);
    plan_req(CMD_SCAN, 1101);       // one above threshold
    plan_req(CMD_SCAN, 1100);
    plan_req(CMD_READ, 0);
    plan_req(CMD_SCAN, 1100);       // exactly at threshold: untouched
    plan_req(CMD_SCAN, 1100);
    plan_req(CMD_READ, 0);
    plan_req(CMD_SCAN, 1000);
    plan_req(CMD_SCAN, 16'hFFFF);   // right electrode only
    plan_req(CMD_READ, 0);
    plan_req(CMD_NOP, 16'h5AA5);
    plan_req(CMD_READ, 0);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin ec = 5'd2;  map = {$urandom(), $urandom()}; ln = 8'd255; thr = 16'd0;     end
        1: begin ec = 5'd1;  map = '0;                       ln = 8'd0;   thr = 16'hFFFF;  end
        2: begin ec = 5'd16; map = '1; ln = LEN_W'($urandom()); thr = 16'd1;              end
        3: begin ec = 5'd0;  map = {$urandom(), $urandom()}; ln = 8'd1;   thr = 16'd500;   end
        4: begin
          ec = 5'd31;
          map = {$urandom(), $urandom()};
          ln = LEN_W'($urandom());
          thr = 16'd50;
        end
        default: begin
          ec = EC_W'($urandom_range(2, 4));
          map = {$urandom(), $urandom()};
          ln = LEN_W'($urandom());
          thr = CNT_W'($urandom_range(0, 3000));
        end
      endcase
      // upper data bits random so the register masking is exercised
      word = {$urandom(), $urandom()};
      word[EC_W-1:0] = ec;
      plan_write(CFG_ELEC_COUNT, word);
      plan_write(CFG_CHAN_MAP, map);
      word = {$urandom(), $urandom()};
      word[LEN_W-1:0] = ln;
      plan_write(CFG_SLIDER_LEN, word);
      word = {$urandom(), $urandom()};
      word[CNT_W-1:0] = thr;
      plan_write(CFG_THRESHOLD, word);
      if (ph == 0) plan_write(CFG_SPARE, {$urandom(), $urandom()});

      tx_quiet = ($urandom_range(0, 2) == 0);
      rot = rotation_len(ec);
      lvl = $urandom_range(0, 60000);
      start_n = n_planned;
      for (int k = 0; k < rot; k++) plan_req(CMD_CALIB, clamp16(lvl + $urandom_range(0, 600)));
      while (n_planned - start_n < PHASE_ITEMS) begin
        if (ph == 2 && n_planned - start_n >= 30 && burst_left == 0 && rx_hold_once == 0) begin
          // receiver blocks for a long stretch while requests keep coming
          plan_marker(ACT_HOLD);
          burst_left = 14;
          rx_hold_once = 1;
        end
        if (ph == 4 && n_planned - start_n >= 40 && drain_once == 0) begin
          plan_marker(ACT_DRAIN);
          drain_once = 1;
        end
        case ($urandom_range(0, 9))
          0, 1: begin
            for (int k = 0; k < rot; k++)
              plan_req(CMD_CALIB, clamp16(lvl + $urandom_range(0, 600)));
          end
          2, 3, 4, 5, 6: begin
            for (int k = 0; k < rot; k++) begin
              if ($urandom_range(0, 3) == 0) offs = -int'($urandom_range(0, 2000));
              else offs = $urandom_range(0, 2 * int'(thr > 3000 ? 3000 : thr) + 400);
              plan_req(CMD_SCAN, clamp16(int'(lvl) + offs));
            end
            plan_req(CMD_READ, $urandom());
          end
          7: begin
            plan_req(CMD_READ, $urandom());
            plan_req(($urandom_range(0, 1) != 0) ? CMD_READ : CMD_NOP, $urandom());
          end
          default: plan_req(cmd_t'($urandom_range(0, 3)), $urandom());
        endcase
      end
    end

    wait (rst_n);
    while (plan_q.size() != 0 || in_valid || cfg_valid || n_req < n_planned ||
           slider_readouts_q.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d requests (%0d reads with a touch) and %0d register writes",
             n_req, n_touch, n_cfg);
    $display("over %0d register settings; %0d readouts checked, %0d mismatches",
             PHASES + 1, n_res, mismatches);
    if (mismatches == 0 && slider_readouts_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/tss_pkg.sv
rtl/core/tss_table.sv
rtl/core/tss_divider.sv
rtl/core/tss_position.sv
rtl/core/touch_slider_scanner_core.sv
verif/tb_touch_slider_scanner_core.sv
